FILE: rtl/isq_pkg.sv
// ----------------------------------------------------------------------------
// Indexed sequence store package
// Shared widths, status codes, operation codes and the command that steers the
// element cells.
// ----------------------------------------------------------------------------
package isq_pkg;

   // Field widths of the request and response transactions.
   localparam int DATA_W = 32;
   localparam int POS_W  = 8;
   localparam int OP_W   = 4;
   localparam int ST_W   = 2;

   // Default number of element cells.
   localparam int CAPACITY_DEF = 256;

   // Response status codes.
   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
   localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

   // Operation codes carried by a request transaction.
   typedef enum logic [OP_W-1:0] {
      OP_CLEAR      = 4'd0,
      OP_APPEND     = 4'd1,
      OP_PREPEND    = 4'd2,
      OP_INSERT     = 4'd3,
      OP_REMOVE     = 4'd4,
      OP_READ       = 4'd5,
      OP_TAKE_FRONT = 4'd6,
      OP_POP_BACK   = 4'd7,
      OP_FRONT      = 4'd8,
      OP_BACK       = 4'd9
   } op_type;

   // What every cell does with its element.
   typedef enum logic [1:0] {
      CK_HOLD,
      CK_INSERT,
      CK_APPEND,
      CK_REMOVE
   } cell_kind_type;

   // Control broadcast from the sequencer to the row of cells.
   typedef struct packed {
      cell_kind_type kind;
      logic          walk;
   } cell_cmd_type;

endpackage

FILE: rtl/indexed_sequence_store.sv
// ----------------------------------------------------------------------------
// Indexed sequence store
// Bounded ordered sequence of signed 32-bit values held in a row of cells.
// ----------------------------------------------------------------------------
// Each request transaction carries one operation and yields one response
// transaction with status, data and the new count. Clear, append, prepend,
// insert, remove, pop front, front and every error case need no walk, so a
// new request is taken in the cycle after the previous one when the
// receiver is ready. Read, back and pop back fetch their data along the read
// chain through the cells, one cell per cycle towards the head, starting at
// the position read (count - 1 for back and pop back). Only one request is
// in progress at a time, and a response waiting in the output register holds
// off the next request until the receiver takes it.
// ----------------------------------------------------------------------------
module indexed_sequence_store #(
   parameter int CAPACITY = isq_pkg::CAPACITY_DEF,
   parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [isq_pkg::OP_W-1:0]          req_operation,
   input  logic [isq_pkg::POS_W-1:0]         req_position,
   input  logic signed [isq_pkg::DATA_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [isq_pkg::ST_W-1:0]          rsp_status,
   output logic signed [isq_pkg::DATA_W-1:0] rsp_data,
   output logic [CNT_W-1:0]                  rsp_count
);
   import isq_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_DONE
   } state_type;

   state_type         state_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [IDX_W-1:0]  walk_pos_ff;
   logic [IDX_W-1:0]  walk_cnt_ff;
   logic              rsp_valid_ff;
   logic [ST_W-1:0]   rsp_status_ff;
   logic [DATA_W-1:0] rsp_data_ff;
   logic [CNT_W-1:0]  rsp_count_ff;

   logic              req_fire;
   logic              out_free;
   logic              rsp_load;
   logic              is_full;
   logic              is_empty;
   logic              pos_bad;
   logic [IDX_W-1:0]  pos_idx;
   logic [IDX_W-1:0]  last_idx;

   logic              dec_walk;
   cell_kind_type     dec_kind;
   logic [IDX_W-1:0]  dec_pos;
   logic [ST_W-1:0]   dec_status;
   logic [DATA_W-1:0] dec_data;
   logic [CNT_W-1:0]  dec_count;

   cell_cmd_type      cell_cmd;
   logic [DATA_W-1:0] elem [CAPACITY];
   logic [DATA_W-1:0] rd   [CAPACITY];

   // Handshake and simple conditions on the current count.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign req_fire  = req_valid && req_ready;
   assign is_full   = (count_ff == CNT_W'(CAPACITY));
   assign is_empty  = (count_ff == '0);
   assign pos_bad   = (CMP_W'(req_position) >= CMP_W'(count_ff));
   assign pos_idx   = IDX_W'(req_position);
   assign last_idx  = IDX_W'(count_ff - CNT_W'(1));

   // Decode of the operation into a cell command and a response.
   always_comb begin
      dec_walk   = 1'b0;
      dec_kind   = CK_HOLD;
      dec_pos    = pos_idx;
      dec_status = ST_OK;
      dec_data   = '0;
      dec_count  = count_ff;
      unique case (op_type'(req_operation))
         OP_CLEAR: begin
            dec_count = '0;
         end
         OP_APPEND: begin
            if (is_full) begin
               dec_status = ST_FULL;
            end else begin
               dec_kind  = CK_APPEND;
               dec_pos   = IDX_W'(count_ff);
               dec_count = count_ff + CNT_W'(1);
            end
         end
         OP_PREPEND: begin
            if (is_full) begin
               dec_status = ST_FULL;
            end else begin
               dec_kind  = CK_INSERT;
               dec_pos   = '0;
               dec_count = count_ff + CNT_W'(1);
            end
         end
         OP_INSERT: begin
            if (pos_bad) begin
               dec_status = ST_RANGE;
            end else if (is_full) begin
               dec_status = ST_FULL;
            end else begin
               dec_kind  = CK_INSERT;
               dec_count = count_ff + CNT_W'(1);
            end
         end
         OP_REMOVE: begin
            if (pos_bad) begin
               dec_status = ST_RANGE;
            end else begin
               dec_kind  = CK_REMOVE;
               dec_count = count_ff - CNT_W'(1);
            end
         end
         OP_READ: begin
            if (pos_bad) begin
               dec_status = ST_RANGE;
            end else begin
               dec_walk = 1'b1;
            end
         end
         OP_TAKE_FRONT: begin
            if (is_empty) begin
               dec_status = ST_EMPTY;
            end else begin
               dec_data  = elem[0];
               dec_kind  = CK_REMOVE;
               dec_pos   = '0;
               dec_count = count_ff - CNT_W'(1);
            end
         end
         OP_POP_BACK: begin
            if (is_empty) begin
               dec_status = ST_EMPTY;
            end else begin
               dec_walk  = 1'b1;
               dec_pos   = last_idx;
               dec_count = count_ff - CNT_W'(1);
            end
         end
         OP_FRONT: begin
            if (is_empty) begin
               dec_status = ST_EMPTY;
            end else begin
               dec_data = elem[0];
            end
         end
         OP_BACK: begin
            if (is_empty) begin
               dec_status = ST_EMPTY;
            end else begin
               dec_walk = 1'b1;
               dec_pos  = last_idx;
            end
         end
         default: begin
            dec_status = ST_OK;
         end
      endcase
   end

   // Cell elements change only in the cycle a request transaction is taken.
   assign cell_cmd.kind = req_fire ? dec_kind : CK_HOLD;
   assign cell_cmd.walk = (state_ff == S_WALK);

   // A response is loaded after a request that needs no walk or at the end of a walk.
   assign rsp_load = (req_fire && !dec_walk) || ((state_ff == S_DONE) && out_free);

   // Sequencer, element count and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  count_ff <= dec_count;
                  if (dec_walk) begin
                     walk_pos_ff <= dec_pos;
                     walk_cnt_ff <= dec_pos;
                     state_ff    <= S_WALK;
                  end else begin
                     rsp_status_ff <= dec_status;
                     rsp_data_ff   <= dec_data;
                     rsp_count_ff  <= dec_count;
                  end
               end
            end
            S_WALK: begin
               if (walk_cnt_ff == '0) begin
                  state_ff <= S_DONE;
               end else begin
                  walk_cnt_ff <= walk_cnt_ff - IDX_W'(1);
               end
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_status_ff <= ST_OK;
                  rsp_data_ff   <= rd[0];
                  rsp_count_ff  <= count_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_count  = rsp_count_ff;

   // Row of element cells, head at index zero.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] left_data;
      logic [DATA_W-1:0] right_data;
      logic [DATA_W-1:0] rd_next;

      if (i == 0) begin : g_head
         assign left_data = req_value;
      end else begin : g_body_l
         assign left_data = elem[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_data = elem[i];
         assign rd_next    = elem[i];
      end else begin : g_body_r
         assign right_data = elem[i+1];
         assign rd_next    = rd[i+1];
      end

      isq_cell #(
         .IDX_W (IDX_W),
         .INDEX (i)
      ) u_cell (
         .clock    (clock),
         .cmd      (cell_cmd),
         .pos      (dec_pos),
         .walk_pos (walk_pos_ff),
         .value    (req_value),
         .left     (left_data),
         .right    (right_data),
         .rd_in    (rd_next),
         .elem     (elem[i]),
         .rd       (rd[i])
      );
   end

   // The count never passes the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count above capacity");

   // An operation that needs no walk has its response valid in the next cycle.
   a_quick_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire && !dec_walk |=> rsp_valid_ff)
      else $error("no response after single-cycle operation");

   // The count changes only when a request transaction is taken.
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(count_ff))
      else $error("element count changed without a request");

   // No request is taken while a read walks the chain.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_ready)
      else $error("request taken while busy");

endmodule

FILE: rtl/isq_cell.sv
// ----------------------------------------------------------------------------
// Indexed sequence store element cell
// Holds one element, shifts it to or from its neighbours, and during a walk
// passes read data one cell towards the head of the row per cycle.
// ----------------------------------------------------------------------------
module isq_cell #(
   parameter int IDX_W = 8,
   parameter int INDEX = 0
) (
   input  logic                       clock,
   input  isq_pkg::cell_cmd_type      cmd,
   input  logic [IDX_W-1:0]           pos,
   input  logic [IDX_W-1:0]           walk_pos,
   input  logic [isq_pkg::DATA_W-1:0] value,
   input  logic [isq_pkg::DATA_W-1:0] left,
   input  logic [isq_pkg::DATA_W-1:0] right,
   input  logic [isq_pkg::DATA_W-1:0] rd_in,
   output logic [isq_pkg::DATA_W-1:0] elem,
   output logic [isq_pkg::DATA_W-1:0] rd
);
   import isq_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [DATA_W-1:0] elem_ff;
   logic [DATA_W-1:0] elem_in;
   logic [DATA_W-1:0] rd_ff;

   // Element update for the broadcast command.
   always_comb begin
      elem_in = elem_ff;
      unique case (cmd.kind)
         CK_HOLD: begin
            elem_in = elem_ff;
         end
         CK_INSERT: begin
            if (MY_IDX == pos) begin
               elem_in = value;
            end else if (MY_IDX > pos) begin
               elem_in = left;
            end
         end
         CK_APPEND: begin
            if (MY_IDX == pos) begin
               elem_in = value;
            end
         end
         CK_REMOVE: begin
            if (MY_IDX >= pos) begin
               elem_in = right;
            end
         end
         default: begin
            elem_in = elem_ff;
         end
      endcase
   end

   // Element and read chain registers; during a walk the selected cell loads its
   // own element into the read chain, the others copy their right-hand neighbour.
   always_ff @(posedge clock) begin
      elem_ff <= elem_in;
      if (cmd.walk) begin
         rd_ff <= (MY_IDX == walk_pos) ? elem_ff : rd_in;
      end
   end

   assign elem = elem_ff;
   assign rd   = rd_ff;

endmodule
